// ----- rtl/mesh_node_route_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mesh node route table unit
// Implication and next-cycle checks, compiled out in synthesis.
// ----------------------------------------------------------------------------
`ifndef MESH_NODE_ROUTE_TABLE_UNIT_ASSERT_SVH
`define MESH_NODE_ROUTE_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MNTU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mntu: implication check failed");
`define MNTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mntu: next-cycle check failed");
`else
`define MNTU_ASSERT_IMP(label, clk, rst, ante, cons)
`define MNTU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/mntu_pkg.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table package
// Widths, codes and shared types of the neighbour table unit.
// ----------------------------------------------------------------------------
package mntu_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CMD_W  = 2;
   localparam int ID_W   = 8;
   localparam int TYPE_W = 8;
   localparam int FUNC_W = 16;
   localparam int DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [TYPE_W-1:0] TYPE_REFRESH   = 8'h00;
   localparam logic [TYPE_W-1:0] TYPE_INFO      = 8'h01;
   localparam logic [TYPE_W-1:0] TYPE_ADD       = 8'h02;
   localparam logic [TYPE_W-1:0] TYPE_DATA      = 8'hff;
   localparam logic [ID_W-1:0]   ADDR_BROADCAST = 8'hff;
   localparam logic [ID_W-1:0]   ADDR_ROOT      = 8'h00;

   localparam logic [ID_W-1:0]   NODE_ID_RESET       = 8'h01;
   localparam logic [FUNC_W-1:0] NODE_FUNCTION_RESET = 16'h0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECEIVE = 2'd0,
      CMD_MCAST   = 2'd1,
      CMD_DIRECT  = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NODE_ID       = 1'd0,
      REG_NODE_FUNCTION = 1'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic {
      OP_ADD,
      OP_MCAST
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [FUNC_W-1:0] func;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

   typedef struct packed {
      logic             shift;
      logic             write;
      logic [IDX_W-1:0] wr_index;
      entry_type        wr_entry;
   } chain_ctl_type;

   typedef struct packed {
      logic              frame_valid;
      logic [ID_W-1:0]   frame_source;
      logic [ID_W-1:0]   frame_destination;
      logic [TYPE_W-1:0] frame_type;
      logic [DATA_W-1:0] frame_data;
      logic              accepted;
      logic              handled;
      logic              last;
   } result_type;

endpackage

// ----- rtl/mntu_channels.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table channels
// Valid/ready interfaces for request, response and register write items.
// ----------------------------------------------------------------------------
interface mntu_req_if;
   import mntu_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TYPE_W-1:0] msg_type;
   logic [ID_W-1:0]   source_id;
   logic [ID_W-1:0]   destination_id;
   logic [DATA_W-1:0] payload;

   modport source (output valid, cmd, msg_type, source_id, destination_id, payload,
                   input ready);
   modport sink (input valid, cmd, msg_type, source_id, destination_id, payload,
                 output ready);
endinterface

interface mntu_rsp_if;
   import mntu_pkg::*;
   logic              valid;
   logic              ready;
   logic              frame_valid;
   logic [ID_W-1:0]   frame_source;
   logic [ID_W-1:0]   frame_destination;
   logic [TYPE_W-1:0] frame_type;
   logic [DATA_W-1:0] frame_data;
   logic              accepted;
   logic              handled;
   logic              last;

   modport source (output valid, frame_valid, frame_source, frame_destination,
                   frame_type, frame_data, accepted, handled, last,
                   input ready);
   modport sink (input valid, frame_valid, frame_source, frame_destination,
                 frame_type, frame_data, accepted, handled, last,
                 output ready);
endinterface

interface mntu_csr_if;
   import mntu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mntu_cell.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table cell
// Holds one neighbour entry and takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module mntu_cell (
   input  logic                 clock,
   input  mntu_pkg::cell_ctl_type ctl,
   input  mntu_pkg::entry_type  wr_entry,
   input  mntu_pkg::entry_type  next_entry,
   output mntu_pkg::entry_type  entry
);
   import mntu_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         entry_ff <= wr_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/mntu_chain.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table cell ring
// A ring of entry cells that rotates towards cell 0, which faces the control.
// ----------------------------------------------------------------------------
module mntu_chain (
   input  logic                   clock,
   input  mntu_pkg::chain_ctl_type ctl,
   output mntu_pkg::entry_type    head
);
   import mntu_pkg::*;

   entry_type cell_entry [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cell_ctl_type cell_ctl;

      assign cell_ctl.shift = ctl.shift;
      assign cell_ctl.write = ctl.write && (ctl.wr_index == IDX_W'(i));

      mntu_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .wr_entry   (ctl.wr_entry),
         .next_entry (cell_entry[(i + 1) % TABLE_DEPTH]),
         .entry      (cell_entry[i])
      );
   end

   assign head = cell_entry[0];

endmodule

// ----- rtl/mesh_node_route_table_unit.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table unit
// Neighbour table of a mesh node working on decoded frame fields.
// ----------------------------------------------------------------------------
// One item is taken at a time. A directed send, an unused command and a
// received frame other than an add request are dealt with in the cycle in
// which they are accepted. An add request and a multicast send are accepted,
// then rotate the full ring of TABLE_DEPTH cells once, one cell per cycle
// unless a multicast hit waits on the output, and then finish in ST_FINISH,
// where a multicast also waits for room on the output. A result that waits
// on the output holds off the next item.
module mesh_node_route_table_unit (
   input logic       clock,
   input logic       reset,
   mntu_req_if.sink  req_chan,
   mntu_rsp_if.source rsp_chan,
   mntu_csr_if.sink  csr_chan
);
   import mntu_pkg::*;

   `include "mesh_node_route_table_unit_assert.svh"

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dup_ff, dup_in;
   logic              self_ff, self_in;
   logic [ID_W-1:0]   src_ff, src_in;
   logic [DATA_W-1:0] data_ff, data_in;
   result_type        pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   node_id_ff, node_id_in;
   logic [FUNC_W-1:0] node_function_ff, node_function_in;

   chain_ctl_type chain_ctl;
   entry_type     head;
   logic          out_room;
   logic          out_push;
   result_type    out_data;
   logic          req_fire;
   logic          in_range;
   logic          hit;
   logic          last_step;
   logic          advance;
   result_type    res;

   mntu_chain u_chain (
      .clock (clock),
      .ctl   (chain_ctl),
      .head  (head)
   );

   assign out_room  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_room;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign in_range  = CNT_W'(step_ff) < count_ff;
   assign hit       = in_range && ((head.func & node_function_ff) != '0);
   assign last_step = step_ff == IDX_W'(TABLE_DEPTH - 1);

   always_comb begin
      node_id_in       = node_id_ff;
      node_function_in = node_function_ff;
      if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.index))
            REG_NODE_ID:       node_id_in = csr_chan.data[ID_W-1:0];
            REG_NODE_FUNCTION: node_function_in = csr_chan.data[FUNC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      dup_in        = dup_ff;
      self_in       = self_ff;
      src_in        = src_ff;
      data_in       = data_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_push      = 1'b0;
      out_data      = '0;
      chain_ctl     = '0;
      advance       = 1'b0;
      res           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res.last = 1'b1;
               src_in   = req_chan.source_id;
               data_in  = req_chan.payload;
               case (cmd_code_type'(req_chan.cmd))
                  CMD_RECEIVE: begin
                     res.accepted = (req_chan.source_id != node_id_ff) &&
                                    ((req_chan.destination_id == node_id_ff) ||
                                     (req_chan.destination_id == ADDR_BROADCAST));
                     if (req_chan.msg_type == TYPE_REFRESH) begin
                        count_in              = '0;
                        res.handled           = 1'b1;
                        res.frame_valid       = 1'b1;
                        res.frame_source      = node_id_ff;
                        res.frame_destination = ADDR_ROOT;
                        res.frame_type        = TYPE_INFO;
                        res.frame_data        = node_function_ff;
                     end else if (req_chan.msg_type == TYPE_ADD) begin
                        res.handled = 1'b1;
                        op_in       = OP_ADD;
                        dup_in      = 1'b0;
                        self_in     = req_chan.source_id == node_id_ff;
                        step_in     = '0;
                        state_in    = ST_SCAN;
                     end
                     out_push = 1'b1;
                     out_data = res;
                  end
                  CMD_MCAST: begin
                     op_in         = OP_MCAST;
                     pend_valid_in = 1'b0;
                     step_in       = '0;
                     state_in      = ST_SCAN;
                  end
                  CMD_DIRECT: begin
                     res.frame_valid       = 1'b1;
                     res.frame_source      = node_id_ff;
                     res.frame_destination = req_chan.destination_id;
                     res.frame_type        = TYPE_DATA;
                     res.frame_data        = req_chan.payload;
                     out_push = 1'b1;
                     out_data = res;
                  end
                  default: begin
                     out_push = 1'b1;
                     out_data = res;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_ADD) begin
               advance = 1'b1;
               if (in_range && (head.id == src_ff)) begin
                  dup_in = 1'b1;
               end
            end else if (!(hit && pend_valid_ff && !out_room)) begin
               advance = 1'b1;
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_push = 1'b1;
                     out_data = pend_ff;
                  end
                  res.frame_valid       = 1'b1;
                  res.frame_source      = node_id_ff;
                  res.frame_destination = head.id;
                  res.frame_type        = TYPE_DATA;
                  res.frame_data        = data_ff;
                  pend_in               = res;
                  pend_valid_in         = 1'b1;
               end
            end
            if (advance) begin
               chain_ctl.shift = 1'b1;
               if (last_step) begin
                  step_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (op_ff == OP_ADD) begin
               if (!dup_ff && !self_ff && (count_ff < CNT_W'(TABLE_DEPTH))) begin
                  chain_ctl.write         = 1'b1;
                  chain_ctl.wr_index      = count_ff[IDX_W-1:0];
                  chain_ctl.wr_entry.id   = src_ff;
                  chain_ctl.wr_entry.func = data_ff;
                  count_in                = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end else if (out_room) begin
               if (pend_valid_ff) begin
                  res = pend_ff;
               end
               res.last      = 1'b1;
               out_push      = 1'b1;
               out_data      = res;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_push) begin
         rsp_in       = out_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         count_ff         <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         node_id_ff       <= NODE_ID_RESET;
         node_function_ff <= NODE_FUNCTION_RESET;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         count_ff         <= count_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         node_id_ff       <= node_id_in;
         node_function_ff <= node_function_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      dup_ff  <= dup_in;
      self_ff <= self_in;
      src_ff  <= src_in;
      data_ff <= data_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.frame_valid       = rsp_ff.frame_valid;
   assign rsp_chan.frame_source      = rsp_ff.frame_source;
   assign rsp_chan.frame_destination = rsp_ff.frame_destination;
   assign rsp_chan.frame_type        = rsp_ff.frame_type;
   assign rsp_chan.frame_data        = rsp_ff.frame_data;
   assign rsp_chan.accepted          = rsp_ff.accepted;
   assign rsp_chan.handled           = rsp_ff.handled;
   assign rsp_chan.last              = rsp_ff.last;

   `MNTU_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `MNTU_ASSERT_IMP(a_ring_restored, clock, reset, state_ff == ST_FINISH, step_ff == '0)
   `MNTU_ASSERT_IMP(a_pend_mcast, clock, reset, pend_valid_ff, op_ff == OP_MCAST)
   `MNTU_ASSERT_NEXT(a_scan_no_push_add, clock, reset,
      (state_ff == ST_SCAN) && (op_ff == OP_ADD), count_ff == $past(count_ff))

endmodule

// ----- verif/mesh_node_route_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// Mesh node route table unit testbench
// Drives received frames, multicast and directed sends and unused commands
// through the request channel and register writes through the register
// channel. A scoreboard keeps its own copy of the neighbour table, predicts
// every outgoing result and compares the block's results with it by field.
// ----------------------------------------------------------------------------
module mesh_node_route_table_unit_test;
   import mntu_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 70;
   localparam int PHASE_COUNT   = 6;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;

   typedef struct packed {
      cmd_code_type      cmd;
      logic [TYPE_W-1:0] msg_type;
      logic [ID_W-1:0]   source_id;
      logic [ID_W-1:0]   destination_id;
      logic [DATA_W-1:0] payload;
   } request_type;

   class route_frame_scoreboard;
      logic [ID_W-1:0]   node_id;
      logic [FUNC_W-1:0] node_function;
      logic [ID_W-1:0]   neighbour_id [TABLE_DEPTH];
      logic [FUNC_W-1:0] neighbour_func [TABLE_DEPTH];
      int                entry_count;
      result_type        expected_frames [$];
      int                mismatches;

      function new();
         node_id       = NODE_ID_RESET;
         node_function = NODE_FUNCTION_RESET;
         entry_count   = 0;
         mismatches    = 0;
      endfunction

      function void write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_NODE_ID) begin
            node_id = value[ID_W-1:0];
         end else begin
            node_function = value[FUNC_W-1:0];
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function result_type frame_result(logic fv, logic [ID_W-1:0] src, logic [ID_W-1:0] dst,
                                        logic [TYPE_W-1:0] ftype, logic [DATA_W-1:0] data,
                                        logic acc, logic hnd);
         result_type res;
         res.frame_valid       = fv;
         res.frame_source      = src;
         res.frame_destination = dst;
         res.frame_type        = ftype;
         res.frame_data        = data;
         res.accepted          = acc;
         res.handled           = hnd;
         res.last              = 1'b0;
         return res;
      endfunction

      function void note_request(request_type r);
         result_type batch [$];
         logic       acc;
         bit         listed;
         acc = (r.source_id != node_id) &&
               (r.destination_id == node_id || r.destination_id == ADDR_BROADCAST);
         case (r.cmd)
            CMD_RECEIVE: begin
               if (r.msg_type == TYPE_REFRESH) begin
                  entry_count = 0;
                  batch.push_back(frame_result(1'b1, node_id, ADDR_ROOT, TYPE_INFO,
                                               node_function, acc, 1'b1));
               end else if (r.msg_type == TYPE_ADD) begin
                  listed = (r.source_id == node_id);
                  for (int i = 0; i < entry_count; i++) begin
                     if (neighbour_id[i] == r.source_id) listed = 1'b1;
                  end
                  if (!listed && entry_count < TABLE_DEPTH) begin
                     neighbour_id[entry_count]   = r.source_id;
                     neighbour_func[entry_count] = r.payload;
                     entry_count++;
                  end
                  batch.push_back(frame_result(1'b0, '0, '0, '0, '0, acc, 1'b1));
               end else begin
                  batch.push_back(frame_result(1'b0, '0, '0, '0, '0, acc, 1'b0));
               end
            end
            CMD_MCAST: begin
               for (int i = 0; i < entry_count; i++) begin
                  if ((node_function & neighbour_func[i]) != '0) begin
                     batch.push_back(frame_result(1'b1, node_id, neighbour_id[i], TYPE_DATA,
                                                  r.payload, 1'b0, 1'b0));
                  end
               end
            end
            CMD_DIRECT: begin
               batch.push_back(frame_result(1'b1, node_id, r.destination_id, TYPE_DATA,
                                            r.payload, 1'b0, 1'b0));
            end
            default: begin
            end
         endcase
         if (batch.size() == 0) begin
            batch.push_back(frame_result(1'b0, '0, '0, '0, '0, 1'b0, 1'b0));
         end
         batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) expected_frames.push_back(batch[i]);
      endfunction

      function bit field_differs(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_result(result_type got);
         result_type want;
         bit         bad;
         if (expected_frames.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_frames.pop_front();
         bad = field_differs("frame_valid", DATA_W'(want.frame_valid),
                             DATA_W'(got.frame_valid));
         bad = field_differs("frame_source", DATA_W'(want.frame_source),
                             DATA_W'(got.frame_source)) | bad;
         bad = field_differs("frame_destination", DATA_W'(want.frame_destination),
                             DATA_W'(got.frame_destination)) | bad;
         bad = field_differs("frame_type", DATA_W'(want.frame_type),
                             DATA_W'(got.frame_type)) | bad;
         bad = field_differs("frame_data", want.frame_data, got.frame_data) | bad;
         bad = field_differs("accepted", DATA_W'(want.accepted),
                             DATA_W'(got.accepted)) | bad;
         bad = field_differs("handled", DATA_W'(want.handled),
                             DATA_W'(got.handled)) | bad;
         bad = field_differs("last", DATA_W'(want.last), DATA_W'(got.last)) | bad;
         if (bad) mismatches++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mntu_req_if req_chan ();
   mntu_rsp_if rsp_chan ();
   mntu_csr_if csr_chan ();

   route_frame_scoreboard scoreboard = new();
   result_type            observed;
   int                    cycle_count = 0;
   int                    items_sent  = 0;
   bit                    idling_on   = 1'b1;
   bit                    hold_rsp    = 1'b0;

   mesh_node_route_table_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         observed.frame_valid       = rsp_chan.frame_valid;
         observed.frame_source      = rsp_chan.frame_source;
         observed.frame_destination = rsp_chan.frame_destination;
         observed.frame_type        = rsp_chan.frame_type;
         observed.frame_data        = rsp_chan.frame_data;
         observed.accepted          = rsp_chan.accepted;
         observed.handled           = rsp_chan.handled;
         observed.last              = rsp_chan.last;
         scoreboard.check_result(observed);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // The receiver idles in bursts and, once, holds off long enough for the block to fill.
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic [ID_W-1:0] pick_destination();
      case ($urandom_range(0, 2))
         0:       return scoreboard.node_id;
         1:       return ADDR_BROADCAST;
         default: return ID_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(cmd_code_type cmd, logic [TYPE_W-1:0] msg_type,
                            logic [ID_W-1:0] src, logic [ID_W-1:0] dst,
                            logic [DATA_W-1:0] payload);
      request_type r;
      r.cmd            = cmd;
      r.msg_type       = msg_type;
      r.source_id      = src;
      r.destination_id = dst;
      r.payload        = payload;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.cmd            <= r.cmd;
      req_chan.msg_type       <= r.msg_type;
      req_chan.source_id      <= r.source_id;
      req_chan.destination_id <= r.destination_id;
      req_chan.payload        <= r.payload;
      do @(posedge clock); while (!req_chan.ready);
      scoreboard.note_request(r);
      items_sent++;
   endtask

   task automatic send_random(cmd_code_type cmd);
      send_item(cmd, TYPE_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                DATA_W'($urandom));
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      scoreboard.write_register(idx, value);
   endtask

   // The upper byte of the identifier write is random and must be ignored.
   task automatic reconfigure(logic [ID_W-1:0] id, logic [FUNC_W-1:0] func);
      logic [7:0] upper;
      upper = 8'($urandom_range(0, 255));
      wait_until_drained();
      write_register(REG_NODE_ID, {upper, id});
      write_register(REG_NODE_FUNCTION, func);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_phase(int count);
      int                stop_at;
      int                adds;
      logic [ID_W-1:0]   base;
      logic [ID_W-1:0]   src;
      logic [FUNC_W-1:0] func;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            send_item(CMD_RECEIVE, TYPE_REFRESH, ID_W'($urandom_range(0, 255)),
                      pick_destination(), DATA_W'($urandom));
            base = ID_W'($urandom_range(0, 255));
            adds = $urandom_range(1, 24);
            repeat (adds) begin
               if ($urandom_range(0, 15) == 0) begin
                  src = scoreboard.node_id;
               end else begin
                  src = base + ID_W'($urandom_range(0, 23));
               end
               if ($urandom_range(0, 1) == 0) begin
                  func = 16'h0001 << $urandom_range(0, 15);
               end else begin
                  func = FUNC_W'($urandom);
               end
               send_item(CMD_RECEIVE, TYPE_ADD, src, pick_destination(), func);
               if ($urandom_range(0, 7) == 0) begin
                  send_random(CMD_MCAST);
               end
            end
            send_random(CMD_MCAST);
            if ($urandom_range(0, 1) == 0) begin
               send_random(CMD_DIRECT);
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_random(cmd_code_type'($urandom_range(0, 3)));
            end
         end
      end
   endtask

   initial begin
      req_chan.valid          <= 1'b0;
      req_chan.cmd            <= CMD_RECEIVE;
      req_chan.msg_type       <= '0;
      req_chan.source_id      <= '0;
      req_chan.destination_id <= '0;
      req_chan.payload        <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= REG_NODE_ID;
      csr_chan.data           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      reconfigure(8'h05, 16'h8001);
      send_item(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 16'hffff);
      send_item(CMD_MCAST, 8'h00, 8'h00, 8'h00, 16'h1234);
      send_item(CMD_RECEIVE, TYPE_REFRESH, 8'h00, 8'h05, 16'h0000);
      send_item(CMD_RECEIVE, TYPE_ADD, 8'h05, 8'h05, 16'hffff);
      send_item(CMD_RECEIVE, TYPE_ADD, 8'h10, ADDR_BROADCAST, 16'h0001);
      send_item(CMD_RECEIVE, TYPE_ADD, 8'h10, 8'h05, 16'hffff);
      send_item(CMD_RECEIVE, TYPE_ADD, 8'h20, 8'h33, 16'h0100);
      send_item(CMD_RECEIVE, TYPE_ADD, 8'hff, 8'h00, 16'h8000);
      send_item(CMD_MCAST, 8'h00, 8'h00, 8'h00, 16'hffff);
      send_item(CMD_RECEIVE, 8'hff, 8'hff, 8'hff, 16'h5a5a);
      send_item(CMD_DIRECT, 8'h00, 8'h00, ADDR_BROADCAST, 16'h0000);
      for (int i = 0; i < 13; i++) begin
         send_item(CMD_RECEIVE, TYPE_ADD, ID_W'(8'h40 + i), 8'h05, 16'hffff);
      end
      send_item(CMD_RECEIVE, TYPE_ADD, 8'h60, 8'h05, 16'hffff);
      send_item(CMD_MCAST, 8'h00, 8'h00, 8'h00, 16'ha5a5);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       reconfigure(8'h00, 16'hffff);
            1:       reconfigure(8'hff, 16'h0001);
            2:       reconfigure(ID_W'($urandom_range(0, 255)),
                                 FUNC_W'($urandom_range(0, 65535)));
            3:       reconfigure(ID_W'($urandom_range(0, 255)), 16'h0000);
            4:       reconfigure(NODE_ID_RESET, FUNC_W'($urandom_range(0, 65535)));
            default: reconfigure(ID_W'($urandom_range(0, 255)), 16'hffff);
         endcase
         if (phase == 1) hold_rsp = 1'b1;
         if (phase == PHASE_COUNT - 1) idling_on = 1'b0;
         run_phase(PHASE_ITEMS);
      end

      wait_until_drained();
      if (scoreboard.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mntu_pkg.sv
rtl/mntu_channels.sv
rtl/mntu_cell.sv
rtl/mntu_chain.sv
rtl/mesh_node_route_table_unit.sv
verif/mesh_node_route_table_unit_test.sv
